FILE: rtl/mpq_pkg.sv
// ----------------------------------------------------------------------------
// mpq_pkg
// Types and constants shared by the min-priority queue and its cell row.
// ----------------------------------------------------------------------------
package mpq_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int KEY_BITS_DEF    = 32;

    localparam int VALUE_W = 32;
    localparam int CNT_O_W = 7;
    localparam int CAP_W   = 7;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_EXTRACT = 2'd1,
        CMD_DELETE  = 2'd2
    } t_mpq_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_MISSING = 2'd3
    } t_mpq_status;

    typedef enum logic {
        S_IDLE  = 1'b0,
        S_APPLY = 1'b1
    } t_mpq_state;

    // what every cell does in the apply cycle
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_SHIFT  = 2'd2,
        OP_REMOVE = 2'd3
    } t_cell_op;

    typedef struct packed {
        logic     cmp_en;
        t_cell_op op;
    } t_cell_ctl;

    typedef struct packed {
        logic [1:0]          cmd;
        logic signed [31:0]  key;
    } t_mpq_in;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [1:0]                status;
        logic [CNT_O_W-1:0]        count;
    } t_mpq_out;

endpackage

FILE: rtl/mpq_cell.sv
// ----------------------------------------------------------------------------
// mpq_cell
// One slot of the sorted key row: compares against the broadcast key, then
// keeps its key or takes one from a neighbor.
// ----------------------------------------------------------------------------
module mpq_cell #(
    parameter int KEY_W = 32,
    parameter int CNT_W = 7,
    parameter int IDX   = 0
) (
    input  logic                    i_clk,
    input  mpq_pkg::t_cell_ctl      i_ctl,
    input  logic signed [KEY_W-1:0] i_cmp_key,
    input  logic signed [KEY_W-1:0] i_new_key,
    input  logic [CNT_W-1:0]        i_count,
    input  logic signed [KEY_W-1:0] i_left_key,
    input  logic                    i_left_le,
    input  logic signed [KEY_W-1:0] i_right_key,
    input  logic                    i_right_le,
    output logic signed [KEY_W-1:0] o_key,
    output logic                    o_le,
    output logic                    o_eq
);
    import mpq_pkg::*;

    logic signed [KEY_W-1:0] r_key;
    logic signed [KEY_W-1:0] n_key;
    logic                    r_le;
    logic                    r_eq;
    logic                    w_valid;

    assign w_valid = CNT_W'(IDX) < i_count;

    // flags: stored key <= broadcast key, stored key == broadcast key
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp_en) begin
            r_le <= w_valid && (r_key <= i_cmp_key);
            r_eq <= w_valid && (r_key == i_cmp_key);
        end
    end

    always_comb begin
        n_key = r_key;
        case (i_ctl.op)
            OP_INSERT: begin
                // row is sorted, so le flags form a prefix; new key lands at its end
                if (!r_le) begin
                    n_key = i_left_le ? i_new_key : i_left_key;
                end
            end
            OP_SHIFT:  n_key = i_right_key;
            OP_REMOVE: begin
                if (!i_right_le) begin
                    n_key = i_right_key;
                end
            end
            default:   n_key = r_key;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_key = r_key;
    assign o_le  = r_le;
    assign o_eq  = r_eq;

endmodule

FILE: rtl/min_priority_queue.sv
// ----------------------------------------------------------------------------
// min_priority_queue
// Min-priority queue of signed keys held in a sorted row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready, i_item) carries one command item:
//   insert, extract minimum or delete key. Each item yields exactly one
//   result item on the output channel (o_valid / i_ready, o_item) with the
//   extracted key, a status code and the entry count after the command.
//   The config channel (i_cfg_valid / o_cfg_ready, i_cfg_data) sets the
//   capacity; write it only while the queue is idle.
//   Timing: in the accept cycle every cell compares its key with the incoming
//   key; in the apply state that follows the whole row shifts by at most one
//   slot and the result is registered. The next item is accepted only after
//   apply returns to idle, so a new item is never taken while one is in apply.
//   If the receiver stalls, the result stays in the output register; one
//   more item can be accepted and compared, and it then waits in its apply
//   cycle until the output register frees.
//   Reset clears the count and sets the capacity to 64. Cell contents are
//   not cleared; slots beyond the count are never used.
// ----------------------------------------------------------------------------
module min_priority_queue #(
    parameter int MAX_ENTRIES = mpq_pkg::MAX_ENTRIES_DEF,
    parameter int KEY_BITS    = mpq_pkg::KEY_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  mpq_pkg::t_mpq_in         i_item,
    output logic                     o_valid,
    input  logic                     i_ready,
    output mpq_pkg::t_mpq_out        o_item,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [mpq_pkg::CAP_W-1:0] i_cfg_data
);
    import mpq_pkg::*;

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int EXT_W = CNT_W + CAP_W;

    t_mpq_state               r_state;
    t_mpq_state               n_state;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic [CAP_W-1:0]         r_capacity;
    logic [1:0]               r_cmd;
    logic signed [KEY_BITS-1:0] r_key;
    logic                     r_out_valid;
    logic                     n_out_valid;
    t_mpq_out                 r_out;

    t_cell_ctl                w_ctl;
    logic                     w_load;
    t_mpq_status              w_status;
    logic signed [VALUE_W-1:0] w_value;
    logic signed [VALUE_W-1:0] w_head_val;
    logic signed [KEY_BITS-1:0] w_in_key;
    logic                     w_full;
    logic                     w_found;
    logic [EXT_W-1:0]         w_cnt_ext;
    logic [EXT_W-1:0]         w_new_cnt_ext;

    logic signed [KEY_BITS-1:0] w_key [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]     w_le;
    logic [MAX_ENTRIES-1:0]     w_eq;

    // narrow keys: truncate in, sign-extend out; wide: zero-extend in, truncate out
    generate
        if (KEY_BITS <= VALUE_W) begin : g_narrow
            assign w_in_key   = i_item.key[KEY_BITS-1:0];
            assign w_head_val = VALUE_W'(w_key[0]);
        end else begin : g_wide
            assign w_in_key   = KEY_BITS'($unsigned(i_item.key));
            assign w_head_val = w_key[0][VALUE_W-1:0];
        end
    endgenerate

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
            mpq_cell #(
                .KEY_W (KEY_BITS),
                .CNT_W (CNT_W),
                .IDX   (gi)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_cmp_key   (w_in_key),
                .i_new_key   (r_key),
                .i_count     (r_count),
                .i_left_key  ((gi == 0) ? r_key : w_key[(gi == 0) ? 0 : gi - 1]),
                .i_left_le   ((gi == 0) ? 1'b1 : w_le[(gi == 0) ? 0 : gi - 1]),
                .i_right_key (w_key[(gi == MAX_ENTRIES - 1) ? gi : gi + 1]),
                .i_right_le  ((gi == MAX_ENTRIES - 1) ? 1'b0
                              : w_le[(gi == MAX_ENTRIES - 1) ? gi : gi + 1]),
                .o_key       (w_key[gi]),
                .o_le        (w_le[gi]),
                .o_eq        (w_eq[gi])
            );
        end
    endgenerate

    assign w_found   = |w_eq;
    assign w_cnt_ext = EXT_W'(r_count);
    assign w_full    = (w_cnt_ext >= EXT_W'(r_capacity))
                    || (w_cnt_ext >= EXT_W'(MAX_ENTRIES));

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_ready;
        w_ctl.cmp_en = 1'b0;
        w_ctl.op     = OP_HOLD;
        w_status    = ST_OK;
        w_value     = '0;
        w_load      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    w_ctl.cmp_en = 1'b1;
                    n_state      = S_APPLY;
                end
            end
            S_APPLY: begin
                if (!r_out_valid || i_ready) begin
                    w_load      = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    unique case (t_mpq_cmd'(r_cmd))
                        CMD_INSERT: begin
                            if (w_full) begin
                                w_status = ST_FULL;
                            end else begin
                                w_ctl.op = OP_INSERT;
                                n_count  = r_count + 1'b1;
                            end
                        end
                        CMD_EXTRACT: begin
                            if (r_count == '0) begin
                                w_status = ST_EMPTY;
                            end else begin
                                w_ctl.op = OP_SHIFT;
                                w_value  = w_head_val;
                                n_count  = r_count - 1'b1;
                            end
                        end
                        CMD_DELETE: begin
                            if (!w_found) begin
                                w_status = ST_MISSING;
                            end else begin
                                // drop the last equal slot, tail moves down one
                                w_ctl.op = OP_REMOVE;
                                n_count  = r_count - 1'b1;
                            end
                        end
                        default: begin
                            w_status = ST_OK;
                        end
                    endcase
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign w_new_cnt_ext = EXT_W'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_capacity  <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_capacity <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.cmp_en) begin
            r_cmd <= i_item.cmd;
            r_key <= w_in_key;
        end
        if (w_load) begin
            r_out.value  <= w_value;
            r_out.status <= w_status;
            r_out.count  <= w_new_cnt_ext[CNT_O_W-1:0];
        end
    end

    // nothing is taken while reset is held
    assign o_ready     = (r_state == S_IDLE) && i_rst_n;
    assign o_valid     = r_out_valid;
    assign o_item      = r_out;
    assign o_cfg_ready = i_rst_n;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        EXT_W'(r_count) <= EXT_W'(MAX_ENTRIES))
        else $error("entry count above row length");

    a_apply_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_valid) |=> (r_state == S_APPLY))
        else $error("accepted item did not reach apply");

    a_out_from_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid || i_ready) && r_state != S_APPLY |=> !r_out_valid)
        else $error("result appeared without an apply cycle");

    a_extract_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_cmd == CMD_EXTRACT && r_count != '0)
        |=> (r_count == $past(r_count) - 1'b1))
        else $error("extract did not decrement count");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY && r_out_valid && !i_ready) |=> $stable(r_count))
        else $error("queue changed while result was stalled");

endmodule

FILE: verif/tb_min_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_min_priority_queue
// Self-checking bench for the min-priority queue: a directed table, then
// phased random commands under several capacity settings, all results checked
// in order against typed table rows, else a binary-heap predictor.
// ----------------------------------------------------------------------------
module tb_min_priority_queue;
    import mpq_pkg::*;

    localparam int                 HEAP_DEPTH  = MAX_ENTRIES_DEF;
    localparam logic [1:0]         CMD_UNKNOWN = 2'd3;
    localparam logic signed [31:0] KEY_MIN     = 32'sh8000_0000;
    localparam logic signed [31:0] KEY_MAX     = 32'sh7FFF_FFFF;

    // random phase mixes
    localparam int MIX_FILL  = 0;
    localparam int MIX_DRAIN = 1;
    localparam int MIX_EVEN  = 2;

    typedef struct {
        t_mpq_in  item;
        bit       typed;
        t_mpq_out res;
    } t_stim_row;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 o_ready;
    t_mpq_in              i_item      = '0;
    logic                 o_valid;
    logic                 i_ready     = 1'b0;
    t_mpq_out             o_item;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CAP_W-1:0]     i_cfg_data  = '0;

    // predicted queue contents
    logic signed [31:0]   heap_key [HEAP_DEPTH];
    int unsigned          heap_len = 0;
    logic [CAP_W-1:0]     heap_cap = CAP_RESET;

    t_mpq_out             pending_results [$];
    int                   idle_pct    = 0;
    int                   rx_hold_len = 0;
    int                   fail_cnt    = 0;
    int                   n_items     = 0;
    int                   n_results   = 0;
    int                   n_full      = 0;
    int                   n_empty     = 0;
    int                   n_missing   = 0;
    int                   n_cfg       = 0;
    int                   max_depth   = 0;

    // phase plan: capacity (-1 picks one at random), length, mix, idling, rx hold
    int ph_cap  [8] = '{127, 5, 1, 0, 64, -1, 64, 64};
    int ph_len  [8] = '{120, 110, 60, 30, 200, 150, 100, 160};
    int ph_mix  [8] = '{MIX_FILL, MIX_DRAIN, MIX_EVEN, MIX_EVEN,
                        MIX_EVEN, MIX_EVEN, MIX_FILL, MIX_EVEN};
    int ph_idle [8] = '{15, 20, 0, 15, 15, 25, 10, 0};
    int ph_hold [8] = '{0, 0, 0, 0, 80, 0, 0, 0};

    min_priority_queue u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_item      (o_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ---------------- heap predictor ----------------
    function automatic void heap_sift_up(input int unsigned start);
        int unsigned        pos;
        int unsigned        up;
        logic signed [31:0] tmp;
        bit                 done;
        pos  = start;
        done = 1'b0;
        while (pos != 0 && !done) begin
            up = (pos - 1) / 2;
            if (heap_key[pos] < heap_key[up]) begin
                tmp           = heap_key[pos];
                heap_key[pos] = heap_key[up];
                heap_key[up]  = tmp;
                pos           = up;
            end else begin
                done = 1'b1;
            end
        end
    endfunction

    function automatic void heap_remove(input int unsigned at);
        int unsigned        pos;
        int unsigned        l;
        int unsigned        r;
        int unsigned        best;
        logic signed [31:0] tmp;
        bit                 done;
        heap_len--;
        if (at != heap_len) begin
            heap_key[at] = heap_key[heap_len];
            heap_sift_up(at);
            // sift down from the original slot
            pos  = at;
            done = 1'b0;
            while (pos < heap_len && !done) begin
                l    = 2 * pos + 1;
                r    = 2 * pos + 2;
                best = pos;
                if (l < heap_len && heap_key[l] < heap_key[best]) best = l;
                if (r < heap_len && heap_key[r] < heap_key[best]) best = r;
                if (best == pos) begin
                    done = 1'b1;
                end else begin
                    tmp            = heap_key[pos];
                    heap_key[pos]  = heap_key[best];
                    heap_key[best] = tmp;
                    pos            = best;
                end
            end
        end
    endfunction

    function automatic t_mpq_out heap_apply_cmd(input t_mpq_in it);
        t_mpq_out    r;
        int unsigned cap_eff;
        int unsigned i;
        bit          hit;
        r       = '0;
        cap_eff = (heap_cap > HEAP_DEPTH) ? HEAP_DEPTH : heap_cap;
        case (it.cmd)
            CMD_INSERT: begin
                if (heap_len >= cap_eff) begin
                    r.status = ST_FULL;
                end else begin
                    heap_key[heap_len] = it.key;
                    heap_len++;
                    heap_sift_up(heap_len - 1);
                end
            end
            CMD_EXTRACT: begin
                if (heap_len == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.value = heap_key[0];
                    heap_remove(0);
                end
            end
            CMD_DELETE: begin
                r.status = ST_MISSING;
                hit      = 1'b0;
                for (i = 0; i < heap_len && !hit; i++) begin
                    if (heap_key[i] == it.key) begin
                        heap_remove(i);
                        r.status = ST_OK;
                        hit      = 1'b1;
                    end
                end
            end
            default: ;   // unknown command leaves the queue alone
        endcase
        r.count = 7'(heap_len);
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic t_stim_row mk_row(input logic [1:0] cmd, input logic signed [31:0] key,
                                         input bit typed, input logic signed [31:0] val,
                                         input logic [1:0] st, input logic [6:0] cnt);
        t_stim_row row;
        row.item.cmd   = cmd;
        row.item.key   = key;
        row.typed      = typed;
        row.res.value  = val;
        row.res.status = st;
        row.res.count  = cnt;
        return row;
    endfunction

    function automatic logic signed [31:0] pick_key();
        int unsigned        r;
        logic signed [31:0] k;
        r = $urandom_range(99);
        if (r < 35) begin
            k = 32'($urandom_range(16)) - 32'sd8;   // tight pool: duplicates, hits
        end else if (r < 60) begin
            k = 32'($urandom_range(2000)) - 32'sd1000;
        end else if (r < 70) begin
            case ($urandom_range(3))
                0: k = KEY_MIN;
                1: k = KEY_MAX;
                2: k = 32'sd0;
                default: k = -32'sd1;
            endcase
        end else begin
            k = $urandom;
        end
        return k;
    endfunction

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic idle_gap();
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    task automatic offer_item(input t_mpq_in it, input bit typed, input t_mpq_out typed_res);
        t_mpq_out pred;
        i_valid <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (!o_ready);
        pred = heap_apply_cmd(it);
        pending_results.push_back(typed ? typed_res : pred);
        n_items++;
        if (heap_len > max_depth) max_depth = heap_len;
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        wait_drained();
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        heap_cap = cap;
        n_cfg++;
    endtask

    // ---------------- receiver ----------------
    initial begin
        int n;
        forever begin
            if (rx_hold_len > 0) begin
                n           = rx_hold_len;
                rx_hold_len = 0;
                i_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // ---------------- result checker ----------------
    always @(posedge i_clk) begin
        t_mpq_out exp_res;
        if (i_rst_n && o_valid && i_ready) begin
            n_results++;
            case (o_item.status)
                ST_FULL:    n_full++;
                ST_EMPTY:   n_empty++;
                ST_MISSING: n_missing++;
                default: ;
            endcase
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result value=%0d status=%0d count=%0d",
                         $time, o_item.value, o_item.status, o_item.count);
                fail_cnt++;
            end else begin
                exp_res = pending_results.pop_front();
                if (o_item.value !== exp_res.value) begin
                    $display("%0t: value mismatch: expected %0d, actual %0d",
                             $time, exp_res.value, o_item.value);
                    fail_cnt++;
                end
                if (o_item.status !== exp_res.status) begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, exp_res.status, o_item.status);
                    fail_cnt++;
                end
                if (o_item.count !== exp_res.count) begin
                    $display("%0t: count mismatch: expected %0d, actual %0d",
                             $time, exp_res.count, o_item.count);
                    fail_cnt++;
                end
            end
        end
    end

    // ---------------- main sequence ----------------
    initial begin
        t_stim_row  dir_tbl [$];
        t_mpq_in    it;
        t_mpq_out   no_res;
        int         p;
        int         k;
        int unsigned r;
        int         lo_ins;
        int         lo_ext;
        int         lo_del;

        no_res = '0;

        // empty queue errors, extremes, duplicates, unknown command
        dir_tbl.push_back(mk_row(CMD_EXTRACT, 32'sd0,   1, 32'sd0, ST_EMPTY,   7'd0));
        dir_tbl.push_back(mk_row(CMD_DELETE,  32'sd5,   1, 32'sd0, ST_MISSING, 7'd0));
        dir_tbl.push_back(mk_row(CMD_UNKNOWN, -32'sd1,  1, 32'sd0, ST_OK,      7'd0));
        dir_tbl.push_back(mk_row(CMD_INSERT,  KEY_MAX,  1, 32'sd0, ST_OK,      7'd1));
        dir_tbl.push_back(mk_row(CMD_INSERT,  KEY_MIN,  1, 32'sd0, ST_OK,      7'd2));
        dir_tbl.push_back(mk_row(CMD_INSERT,  32'sd0,   0, 32'sd0, ST_OK,      7'd0));
        dir_tbl.push_back(mk_row(CMD_INSERT,  -32'sd1,  0, 32'sd0, ST_OK,      7'd0));
        dir_tbl.push_back(mk_row(CMD_INSERT,  32'sd7,   0, 32'sd0, ST_OK,      7'd0));
        dir_tbl.push_back(mk_row(CMD_INSERT,  32'sd7,   1, 32'sd0, ST_OK,      7'd6));
        dir_tbl.push_back(mk_row(CMD_DELETE,  32'sd7,   1, 32'sd0, ST_OK,      7'd5));
        dir_tbl.push_back(mk_row(CMD_DELETE,  32'sd100, 1, 32'sd0, ST_MISSING, 7'd5));
        dir_tbl.push_back(mk_row(CMD_UNKNOWN, KEY_MIN,  1, 32'sd0, ST_OK,      7'd5));
        dir_tbl.push_back(mk_row(CMD_EXTRACT, 32'sd0,   1, KEY_MIN, ST_OK,     7'd4));
        dir_tbl.push_back(mk_row(CMD_EXTRACT, KEY_MAX,  0, 32'sd0, ST_OK,      7'd0));
        dir_tbl.push_back(mk_row(CMD_DELETE,  KEY_MAX,  1, 32'sd0, ST_OK,      7'd2));
        dir_tbl.push_back(mk_row(CMD_EXTRACT, 32'sd0,   0, 32'sd0, ST_OK,      7'd0));
        dir_tbl.push_back(mk_row(CMD_EXTRACT, 32'sd0,   1, 32'sd7, ST_OK,      7'd0));
        dir_tbl.push_back(mk_row(CMD_EXTRACT, 32'sd0,   1, 32'sd0, ST_EMPTY,   7'd0));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_pct = 15;
        foreach (dir_tbl[i]) begin
            idle_gap();
            offer_item(dir_tbl[i].item, dir_tbl[i].typed, dir_tbl[i].res);
        end
        i_valid <= 1'b0;

        for (p = 0; p < 8; p++) begin
            set_capacity(ph_cap[p] < 0 ? 7'($urandom_range(1, HEAP_DEPTH)) : 7'(ph_cap[p]));
            idle_pct    = ph_idle[p];
            rx_hold_len = ph_hold[p];
            case (ph_mix[p])
                MIX_FILL:  begin lo_ins = 80; lo_ext = 92; lo_del = 98; end
                MIX_DRAIN: begin lo_ins = 25; lo_ext = 80; lo_del = 98; end
                default:   begin lo_ins = 45; lo_ext = 75; lo_del = 98; end
            endcase
            for (k = 0; k < ph_len[p]; k++) begin
                r      = $urandom_range(99);
                it.key = pick_key();
                if (r < lo_ins) begin
                    it.cmd = CMD_INSERT;
                end else if (r < lo_ext) begin
                    it.cmd = CMD_EXTRACT;
                end else if (r < lo_del) begin
                    it.cmd = CMD_DELETE;
                    // mostly aim at a stored key
                    if (heap_len != 0 && $urandom_range(99) < 60)
                        it.key = heap_key[$urandom_range(heap_len - 1)];
                end else begin
                    it.cmd = CMD_UNKNOWN;
                end
                idle_gap();
                offer_item(it, 1'b0, no_res);
            end
            i_valid <= 1'b0;
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("ran %0d commands through %0d capacity settings, deepest queue %0d",
                 n_items, n_cfg, max_depth);
        $display("results checked %0d: full %0d, empty %0d, not found %0d",
                 n_results, n_full, n_empty, n_missing);
        if (fail_cnt == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("status: fail");
        $finish;
    end

endmodule
